// File: rtl/swcd_pkg.sv
// ----------------------------------------------------------------------------
// swcd_pkg
// Shared types and constants of the serial word command deframer.
// ----------------------------------------------------------------------------
package swcd_pkg;

	localparam int unsigned SWCD_QUEUE_DEPTH = 4;
	localparam int unsigned WORD_W           = 32;
	localparam int unsigned CFG_INDEX_W      = 1;

	localparam logic [15:0] MIN_PACKET_LEN = 16'd3;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_WORD   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_CODE = 1'd1;

	typedef enum logic [1:0] {
		KIND_PARAM   = 2'd0,
		KIND_NOPARAM = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_COUNT  = 3'd0,
		PH_TYPE   = 3'd1,
		PH_LEN_LO = 3'd2,
		PH_LEN_HI = 3'd3,
		PH_PARAM  = 3'd4
	} phase_t;

	// one queued word: its valid bytes and where they sit in the packet
	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic [2:0]        nbytes;
		logic [15:0]       pos0;
		logic [15:0]       exp_len;
		logic              is_end;
	} swcd_entry_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  command_type;
		logic [15:0] param_length;
		logic [15:0] param_index;
		logic [7:0]  param_byte;
		logic [7:0]  commands_done;
		logic        count_matched;
	} swcd_result_t;

endpackage

// File: rtl/swcd_front.sv
// ----------------------------------------------------------------------------
// swcd_front
// Input side: configuration registers, idle and header filtering, packet
// byte accounting. Each data word of a packet is pushed to the queue.
// ----------------------------------------------------------------------------
module swcd_front import swcd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]      cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [WORD_W-1:0]      link_word,
	input  logic                   queue_full,
	output logic                   push,
	output swcd_entry_t            push_entry
);

	logic [WORD_W-1:0] idle_word_q;
	logic [15:0]       header_code_q;
	logic [15:0]       exp_len_q;
	logic [15:0]       rcv_q;

	logic        accept;
	logic        is_idle;
	logic [15:0] remain;
	logic [2:0]  take;
	logic        at_end;

	always_comb begin
		in_stall = queue_full;
		accept   = in_valid && !queue_full;
		is_idle  = (link_word == idle_word_q);
		remain   = exp_len_q - rcv_q;
		at_end   = (remain <= 16'd4);
		take     = at_end ? remain[2:0] : 3'd4;
		push     = accept && !is_idle && (exp_len_q != 16'd0);

		push_entry.data    = link_word;
		push_entry.nbytes  = take;
		push_entry.pos0    = rcv_q;
		push_entry.exp_len = exp_len_q;
		push_entry.is_end  = at_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_word_q   <= '0;
			header_code_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDLE_WORD:   idle_word_q   <= cfg_data;
				CFG_HEADER_CODE: header_code_q <= cfg_data[15:0];
				default:         ;
			endcase
		end
	end

	// packet framing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= '0;
			rcv_q     <= '0;
		end else if (accept && !is_idle) begin
			if (exp_len_q == 16'd0) begin
				if (link_word[15:0] == header_code_q) begin
					exp_len_q <= link_word[31:16];
					rcv_q     <= '0;
				end
			end else if (at_end) begin
				exp_len_q <= '0;
				rcv_q     <= '0;
			end else begin
				rcv_q <= rcv_q + 16'(take);
			end
		end
	end

endmodule

// File: rtl/swcd_queue.sv
// ----------------------------------------------------------------------------
// swcd_queue
// Short register queue of packet words between the front and the parser.
// ----------------------------------------------------------------------------
module swcd_queue import swcd_pkg::*; #(
	parameter int unsigned DEPTH = SWCD_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  swcd_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        head_valid,
	output swcd_entry_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	swcd_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	always_comb begin
		full       = (count_q == CNT_W'(DEPTH));
		head_valid = (count_q != '0);
		head       = mem_q[rd_ptr_q];
		do_push    = push && !full;
		do_pop     = pop && head_valid;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/swcd_back.sv
// ----------------------------------------------------------------------------
// swcd_back
// Command parser: walks the bytes of each queued word one per cycle unless a
// result is blocked by a stalled output, keeps one result in a hold stage so
// the last result of a word can be marked, and drives the output register.
// ----------------------------------------------------------------------------
module swcd_back import swcd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         head_valid,
	input  swcd_entry_t  head,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_stall,
	output swcd_result_t out_res,
	output logic         out_last
);

	// parse state
	phase_t      phase_q,   phase_d;
	logic [7:0]  decl_q,    decl_d;
	logic [7:0]  ctype_q,   ctype_d;
	logic [15:0] clen_q,    clen_d;
	logic [15:0] ppos_q,    ppos_d;
	logic [7:0]  done_q,    done_d;
	logic        stopped_q, stopped_d;

	logic [2:0]   step_q;
	logic         hold_valid_q;
	swcd_result_t hold_q;
	logic         out_valid_q;
	swcd_result_t out_q;
	logic         out_last_q;

	logic         byte_step;
	logic         end_step;
	logic [7:0]   cur_byte;
	logic [15:0]  pos;
	logic [15:0]  len_full;
	logic [15:0]  ppos_inc;
	logic         overrun;
	logic         gen;
	swcd_result_t gen_res;
	logic         flush;
	logic         out_can;
	logic         go;
	logic         push_out;
	logic         clear;

	always_comb begin
		byte_step = head_valid && (step_q < head.nbytes);
		end_step  = head_valid && !byte_step;
		cur_byte  = 8'(head.data >> {step_q[1:0], 3'b000});
		pos       = head.pos0 + 16'(step_q);
		len_full  = {cur_byte, clen_q[7:0]};
		ppos_inc  = ppos_q + 16'd1;
		overrun   = ({1'b0, pos} + {1'b0, len_full}) > ({1'b0, head.exp_len} - 17'd1);

		phase_d   = phase_q;
		decl_d    = decl_q;
		ctype_d   = ctype_q;
		clen_d    = clen_q;
		ppos_d    = ppos_q;
		done_d    = done_q;
		stopped_d = stopped_q;
		gen       = 1'b0;
		gen_res   = '0;

		if (byte_step && !stopped_q) begin
			case (phase_q)
				PH_COUNT: begin
					decl_d = cur_byte;
					if (cur_byte == 8'd0 || head.exp_len < MIN_PACKET_LEN) begin
						stopped_d = 1'b1;
					end else begin
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					ctype_d = cur_byte;
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					clen_d  = {8'd0, cur_byte};
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					clen_d = len_full;
					if (overrun) begin
						stopped_d = 1'b1;
					end else if (len_full == 16'd0) begin
						gen                  = 1'b1;
						gen_res.kind         = KIND_NOPARAM;
						gen_res.command_type = ctype_q;
						done_d               = done_q + 8'd1;
						phase_d              = PH_TYPE;
					end else begin
						ppos_d  = '0;
						phase_d = PH_PARAM;
					end
				end
				PH_PARAM: begin
					gen                  = 1'b1;
					gen_res.kind         = KIND_PARAM;
					gen_res.command_type = ctype_q;
					gen_res.param_length = clen_q;
					gen_res.param_index  = ppos_q;
					gen_res.param_byte   = cur_byte;
					ppos_d               = ppos_inc;
					if (ppos_inc == clen_q) begin
						done_d  = done_q + 8'd1;
						phase_d = PH_TYPE;
					end
				end
				default: ;
			endcase
		end

		// packet summary, once: the parse clear zeroes the count byte
		if (end_step && head.is_end && head.exp_len >= MIN_PACKET_LEN && decl_q != 8'd0) begin
			gen                   = 1'b1;
			gen_res.kind          = KIND_SUMMARY;
			gen_res.commands_done = done_q;
			gen_res.count_matched = (done_q == decl_q);
		end

		flush    = end_step && !gen;
		out_can  = !out_valid_q || !out_stall;
		go       = head_valid && (!(gen || flush) || !hold_valid_q || out_can);
		push_out = go && hold_valid_q && (gen || flush);
		pop      = go && flush;
		clear    = go && end_step && head.is_end;

		out_valid = out_valid_q;
		out_res   = out_q;
		out_last  = out_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_COUNT;
			decl_q    <= '0;
			ctype_q   <= '0;
			clen_q    <= '0;
			ppos_q    <= '0;
			done_q    <= '0;
			stopped_q <= 1'b0;
		end else if (clear) begin
			phase_q   <= PH_COUNT;
			decl_q    <= '0;
			ctype_q   <= '0;
			clen_q    <= '0;
			ppos_q    <= '0;
			done_q    <= '0;
			stopped_q <= 1'b0;
		end else if (go) begin
			phase_q   <= phase_d;
			decl_q    <= decl_d;
			ctype_q   <= ctype_d;
			clen_q    <= clen_d;
			ppos_q    <= ppos_d;
			done_q    <= done_d;
			stopped_q <= stopped_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (pop) begin
				step_q <= '0;
			end else if (go && byte_step) begin
				step_q <= step_q + 3'd1;
			end

			if (go && gen) begin
				hold_valid_q <= 1'b1;
			end else if (push_out) begin
				hold_valid_q <= 1'b0;
			end

			if (push_out) begin
				out_valid_q <= 1'b1;
				out_last_q  <= flush;
			end else if (out_can) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && gen) begin
			hold_q <= gen_res;
		end
		if (push_out) begin
			out_q <= hold_q;
		end
	end

endmodule

// File: rtl/serial_word_command_deframer_top.sv
// ----------------------------------------------------------------------------
// serial_word_command_deframer_top
// Link word command deframer: framing front, word queue, command parser.
// ----------------------------------------------------------------------------
// usage
//   input channel: one 32-bit link word per handshake (in_valid / in_stall).
//   idle words are dropped, a header word opens a packet, later words carry
//   up to four packet bytes, least significant byte first.
//   output channel: one result word per handshake (out_valid / out_stall);
//   last marks the final result caused by an input word.
//   configuration: cfg_we writes idle_word (index 0) or packet_header_code
//   (index 1) from cfg_data; write only while the block is idle.
//   throughput: the parser walks one byte per cycle unless a result is
//   blocked by a stalled output, then takes a closing step that pops the word
//   (a word that closes a packet with a summary takes an extra closing step
//   first); the front takes a word per cycle while the queue has room.
//   reset: all packet and parse state cleared, both registers zero, queue
//   empty; no results pending.
//   receiver stall: the output register and one hold stage fill, the parser
//   pauses, then the queue fills and in_stall rises.
// ----------------------------------------------------------------------------
module serial_word_command_deframer_top import swcd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = SWCD_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]      cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [31:0]            link_word,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             kind,
	output logic [7:0]             command_type,
	output logic [15:0]            param_length,
	output logic [15:0]            param_index,
	output logic [7:0]             param_byte,
	output logic [7:0]             commands_done,
	output logic                   count_matched,
	output logic                   last
);

	logic         push;
	swcd_entry_t  push_entry;
	logic         queue_full;
	logic         pop;
	logic         head_valid;
	swcd_entry_t  head;
	swcd_result_t out_res;

	swcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.link_word  (link_word),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	swcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	swcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_res    (out_res),
		.out_last   (last)
	);

	assign kind          = out_res.kind;
	assign command_type  = out_res.command_type;
	assign param_length  = out_res.param_length;
	assign param_index   = out_res.param_index;
	assign param_byte    = out_res.param_byte;
	assign commands_done = out_res.commands_done;
	assign count_matched = out_res.count_matched;

endmodule

// File: rtl/swcd_checker.sv
// ----------------------------------------------------------------------------
// swcd_checker
// Port-level checks on the deframer output channel, bound to the top level.
// ----------------------------------------------------------------------------
module swcd_checker import swcd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [15:0] param_index,
	input logic [7:0]  param_byte,
	input logic [7:0]  commands_done,
	input logic        last
);

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(param_byte)
			&& $stable(last))
		else $error("output word changed while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind == KIND_PARAM || kind == KIND_NOPARAM || kind == KIND_SUMMARY)
		else $error("illegal kind code");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_SUMMARY |-> last)
		else $error("summary not last of its word");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_PARAM |-> param_byte == 8'd0 && param_index == 16'd0)
		else $error("parameter fields set outside a parameter byte");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_SUMMARY |-> commands_done == 8'd0)
		else $error("command count set outside a summary");

endmodule

bind serial_word_command_deframer_top swcd_checker u_swcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.kind          (kind),
	.param_index   (param_index),
	.param_byte    (param_byte),
	.commands_done (commands_done),
	.last          (last)
);
